// File: design/dsct_pkg.sv
// Shared types and constants of the deadline sorted callout timer.
// Holds command codes, register indexes, controller states and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package dsct_pkg;

  // Command codes carried in the request tuser
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_AFTER  = 3'd1;
  localparam logic [2:0] CMD_AT     = 3'd2;
  localparam logic [2:0] CMD_EVERY  = 3'd3;
  localparam logic [2:0] CMD_CANCEL = 3'd4;
  localparam logic [2:0] CMD_QUERY  = 3'd5;
  // Spare codes, answered like a query
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] CFG_TICKS_PER_US = 2'd0;
  localparam logic [1:0] CFG_MIN_LEAD     = 2'd1;
  localparam logic [1:0] CFG_MAX_LEAD     = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  TICKS_PER_US_RST = 8'd48;
  localparam logic [15:0] MIN_LEAD_RST     = 16'd50;
  localparam logic [31:0] MAX_LEAD_RST     = 32'd4000000000;

  // Port widths
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RM_WALK,
    S_POST_RM,
    S_EN_WALK,
    S_ACK,
    S_FIRE_CHK,
    S_FIRE_HEAD,
    S_FIRE_PER,
    S_FIRE_OUT,
    S_RS_CALC,
    S_RS_PICK
  } state_e;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_TICK,
    OP_SET_CALLED,
    OP_WALK_CLR,
    OP_WALK_INC,
    OP_RM_SHIFT,
    OP_CANCEL,
    OP_SCHED,
    OP_EN_INSERT,
    OP_ACK,
    OP_FIRE_HEAD,
    OP_FIRE_PER,
    OP_FIRE_OUT,
    OP_RS_CALC,
    OP_RS_PICK
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       e_invalid;
    logic       pending;
    logic       rm_end;
    logic       rm_match;
    logic       en_adv;
    logic       en_full;
    logic       walk_zero;
    logic       due;
    logic       head_fire;
    logic       fire_more;
    logic       per_nz;
    logic       out_free;
    logic       qlen_over;
  } st_t;

endpackage

// File: design/dsct_ctrl.sv
// Controller state machine of the callout timer.
// Sequences removal, sorted insert, firing and compare update; uses dsct_pkg.
`timescale 1ns / 1ps

module dsct_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dsct_pkg::st_t st_i,
  output dsct_pkg::ctl_t ctl_o
);

  dsct_pkg::state_e state_q, state_d;
  logic             fire_q, fire_d;
  logic             sched_cmd;

  assign sched_cmd = (st_i.cmd == dsct_pkg::CMD_AFTER) || (st_i.cmd == dsct_pkg::CMD_AT) ||
                     (st_i.cmd == dsct_pkg::CMD_EVERY) || (st_i.cmd == dsct_pkg::CMD_CANCEL);

  // State and mode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsct_pkg::S_IDLE;
      fire_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fire_q  <= fire_d;
    end
  end

  // Next state and datapath operation
  always_comb begin
    state_d    = state_q;
    fire_d     = fire_q;
    ctl_o.op   = dsct_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      dsct_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.op = dsct_pkg::OP_LATCH;
          state_d  = dsct_pkg::S_DISPATCH;
        end
      end
      dsct_pkg::S_DISPATCH: begin
        if (st_i.cmd == dsct_pkg::CMD_TICK) begin
          ctl_o.op = dsct_pkg::OP_TICK;
          fire_d   = 1'b1;
          state_d  = dsct_pkg::S_FIRE_CHK;
        end else begin
          fire_d = 1'b0;
          if (st_i.e_invalid || !sched_cmd) begin
            ctl_o.op = dsct_pkg::OP_SET_CALLED;
            state_d  = dsct_pkg::S_ACK;
          end else if (st_i.pending) begin
            ctl_o.op = dsct_pkg::OP_WALK_CLR;
            state_d  = dsct_pkg::S_RM_WALK;
          end else begin
            state_d = dsct_pkg::S_POST_RM;
          end
        end
      end
      dsct_pkg::S_RM_WALK: begin
        if (st_i.rm_end) begin
          state_d = dsct_pkg::S_POST_RM;
        end else if (st_i.rm_match) begin
          ctl_o.op = dsct_pkg::OP_RM_SHIFT;
          state_d  = dsct_pkg::S_POST_RM;
        end else begin
          ctl_o.op = dsct_pkg::OP_WALK_INC;
        end
      end
      dsct_pkg::S_POST_RM: begin
        if (st_i.cmd == dsct_pkg::CMD_CANCEL) begin
          ctl_o.op = dsct_pkg::OP_CANCEL;
          state_d  = dsct_pkg::S_ACK;
        end else begin
          ctl_o.op = dsct_pkg::OP_SCHED;
          state_d  = dsct_pkg::S_EN_WALK;
        end
      end
      dsct_pkg::S_EN_WALK: begin
        if (st_i.en_adv) begin
          ctl_o.op = dsct_pkg::OP_WALK_INC;
        end else if (st_i.en_full) begin
          state_d = fire_q ? dsct_pkg::S_FIRE_OUT : dsct_pkg::S_ACK;
        end else begin
          ctl_o.op = dsct_pkg::OP_EN_INSERT;
          if (fire_q) state_d = dsct_pkg::S_FIRE_OUT;
          else if (st_i.walk_zero) state_d = dsct_pkg::S_RS_CALC;
          else state_d = dsct_pkg::S_ACK;
        end
      end
      dsct_pkg::S_ACK: begin
        if (st_i.out_free) begin
          ctl_o.op = dsct_pkg::OP_ACK;
          state_d  = dsct_pkg::S_IDLE;
        end
      end
      dsct_pkg::S_FIRE_CHK: begin
        if (!st_i.due) state_d = dsct_pkg::S_IDLE;
        else if (st_i.head_fire) state_d = dsct_pkg::S_FIRE_HEAD;
        else state_d = dsct_pkg::S_RS_CALC;
      end
      dsct_pkg::S_FIRE_HEAD: begin
        ctl_o.op = dsct_pkg::OP_FIRE_HEAD;
        state_d  = dsct_pkg::S_FIRE_PER;
      end
      dsct_pkg::S_FIRE_PER: begin
        ctl_o.op = dsct_pkg::OP_FIRE_PER;
        state_d  = st_i.per_nz ? dsct_pkg::S_EN_WALK : dsct_pkg::S_FIRE_OUT;
      end
      dsct_pkg::S_FIRE_OUT: begin
        if (st_i.out_free) begin
          ctl_o.op = dsct_pkg::OP_FIRE_OUT;
          state_d  = st_i.fire_more ? dsct_pkg::S_FIRE_HEAD : dsct_pkg::S_RS_CALC;
        end
      end
      dsct_pkg::S_RS_CALC: begin
        ctl_o.op = dsct_pkg::OP_RS_CALC;
        state_d  = dsct_pkg::S_RS_PICK;
      end
      dsct_pkg::S_RS_PICK: begin
        ctl_o.op = dsct_pkg::OP_RS_PICK;
        state_d  = fire_q ? dsct_pkg::S_IDLE : dsct_pkg::S_ACK;
      end
      default: state_d = dsct_pkg::S_IDLE;
    endcase
  end

endmodule

// File: design/dsct_dpath.sv
// Datapath of the callout timer: timebase, sorted queue slots, period
// memory, compare time and result register. Uses dsct_pkg.
`timescale 1ns / 1ps

module dsct_dpath #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned MAX_FIRE  = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [dsct_pkg::IN_TDATA_W-1:0]    in_data_i,
  input  logic [2:0]                         in_cmd_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dsct_pkg::OUT_TDATA_W-1:0]   out_data_o,
  output logic                               out_kind_o,
  output logic                               out_last_o,
  input  logic                               cfg_we_i,
  input  logic [dsct_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [dsct_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  dsct_pkg::ctl_t                     ctl_i,
  output dsct_pkg::st_t                      st_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned WW = $clog2(ENTRIES + 1);
  localparam int unsigned NW = $clog2(MAX_FIRE + 1);
  localparam int unsigned TB = TIME_BITS;

  function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a, input logic [TB-1:0] b);
    logic [TB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TB] ? {TB{1'b1}} : s[TB-1:0];
  endfunction

  // Configuration and timebase
  logic [7:0]    tpu_q;
  logic [15:0]   minl_q;
  logic [31:0]   maxl_q;
  logic [TB-1:0] now_q, cmp_q;
  logic [7:0]    sub_q;

  // Request fields and working values
  logic [2:0]    cmd_q;
  logic [3:0]    e_q;
  logic [IW-1:0] ent_q;
  logic [TB-1:0] tv_q, iv_q, d_q, old_q, soon_q, far_q;
  logic          called_q;
  logic [WW-1:0] walk_q, qlen_q;
  logic [NW-1:0] n_q;

  // Entry state and queue slots
  logic [ENTRIES-1:0] pend_q;
  logic [IW-1:0]      qent_q [ENTRIES];
  logic [TB-1:0]      qdl_q  [ENTRIES];
  logic [IW-1:0]      dn_ent [ENTRIES];
  logic [TB-1:0]      dn_dl  [ENTRIES];
  logic [IW-1:0]      up_ent [ENTRIES];
  logic [TB-1:0]      up_dl  [ENTRIES];

  // Period memory
  logic [TB-1:0] per_mem [ENTRIES];
  logic [TB-1:0] per_rd_q;
  logic          per_we;
  logic [TB-1:0] per_wdata;

  // Output register
  logic       ov_q, okind_q, olast_q, ocalled_q;
  logic [3:0] oent_q;

  logic [63:0]   tv64, iv64;
  logic [IW-1:0] walk_idx;
  logic [8:0]    sub_inc;
  logic          out_free, head_fire, fire_more, out_load;

  assign tv64     = 64'(in_data_i[51:4]);
  assign iv64     = 64'(in_data_i[99:52]);
  assign walk_idx = walk_q[IW-1:0];
  assign sub_inc  = {1'b0, sub_q} + 9'd1;
  assign out_free = !ov_q || out_ready_i;
  assign out_load = (ctl_i.op == dsct_pkg::OP_ACK) || (ctl_i.op == dsct_pkg::OP_FIRE_OUT);
  assign head_fire = (qlen_q != '0) && (qdl_q[0] <= now_q);
  assign fire_more = ((n_q + NW'(1)) < NW'(MAX_FIRE)) && head_fire;

  // Status toward the controller
  always_comb begin
    st_o.cmd       = cmd_q;
    st_o.e_invalid = 32'(e_q) >= 32'(ENTRIES);
    st_o.pending   = pend_q[ent_q];
    st_o.rm_end    = walk_q >= qlen_q;
    st_o.rm_match  = (walk_q < qlen_q) && (qent_q[walk_idx] == ent_q);
    st_o.en_adv    = (walk_q < qlen_q) && (qdl_q[walk_idx] <= d_q);
    st_o.en_full   = qlen_q >= WW'(ENTRIES);
    st_o.walk_zero = walk_q == '0;
    st_o.due       = now_q >= cmp_q;
    st_o.head_fire = head_fire;
    st_o.fire_more = fire_more;
    st_o.per_nz    = per_rd_q != '0;
    st_o.out_free  = out_free;
    st_o.qlen_over = qlen_q > WW'(ENTRIES);
  end

  // Shifted slot views for removal and insertion
  for (genvar j = 0; j < ENTRIES; j++) begin : g_shift
    if (j < ENTRIES - 1) begin : g_dn
      assign dn_ent[j] = qent_q[j+1];
      assign dn_dl[j]  = qdl_q[j+1];
    end else begin : g_dn_end
      assign dn_ent[j] = qent_q[j];
      assign dn_dl[j]  = qdl_q[j];
    end
    if (j > 0) begin : g_up
      assign up_ent[j] = qent_q[j-1];
      assign up_dl[j]  = qdl_q[j-1];
    end else begin : g_up_end
      assign up_ent[j] = qent_q[j];
      assign up_dl[j]  = qdl_q[j];
    end
  end

  // Queue slots: shift down on removal or a fired head, open a gap on insert
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < ENTRIES; j++) begin
      case (ctl_i.op)
        dsct_pkg::OP_RM_SHIFT: begin
          if (WW'(j) >= walk_q) begin
            qent_q[j] <= dn_ent[j];
            qdl_q[j]  <= dn_dl[j];
          end
        end
        dsct_pkg::OP_FIRE_HEAD: begin
          qent_q[j] <= dn_ent[j];
          qdl_q[j]  <= dn_dl[j];
        end
        dsct_pkg::OP_EN_INSERT: begin
          if (WW'(j) == walk_q) begin
            qent_q[j] <= ent_q;
            qdl_q[j]  <= d_q;
          end else if (WW'(j) > walk_q) begin
            qent_q[j] <= up_ent[j];
            qdl_q[j]  <= up_dl[j];
          end
        end
        default: ;
      endcase
    end
  end

  // Period memory: one write port, one registered read port
  always_comb begin
    per_we    = 1'b0;
    per_wdata = '0;
    if (ctl_i.op == dsct_pkg::OP_CANCEL) begin
      per_we = 1'b1;
    end else if (ctl_i.op == dsct_pkg::OP_SCHED) begin
      per_we    = 1'b1;
      per_wdata = (cmd_q == dsct_pkg::CMD_EVERY) ? iv_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (per_we) per_mem[ent_q] <= per_wdata;
    if (ctl_i.op == dsct_pkg::OP_FIRE_HEAD) per_rd_q <= per_mem[qent_q[0]];
  end

  // Working payload registers
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      dsct_pkg::OP_LATCH: begin
        cmd_q <= in_cmd_i;
        e_q   <= in_data_i[3:0];
        ent_q <= IW'(in_data_i[3:0]);
        tv_q  <= tv64[TB-1:0];
        iv_q  <= iv64[TB-1:0];
      end
      dsct_pkg::OP_SET_CALLED: called_q <= st_o.e_invalid || !pend_q[ent_q];
      dsct_pkg::OP_CANCEL:     called_q <= 1'b1;
      dsct_pkg::OP_SCHED: begin
        d_q      <= (cmd_q == dsct_pkg::CMD_AT) ? tv_q : sat_add(now_q, tv_q);
        called_q <= 1'b0;
      end
      dsct_pkg::OP_FIRE_HEAD: begin
        ent_q <= qent_q[0];
        old_q <= qdl_q[0];
      end
      dsct_pkg::OP_FIRE_PER: begin
        if (per_rd_q != '0) begin
          d_q      <= sat_add(old_q, per_rd_q);
          called_q <= 1'b0;
        end else begin
          called_q <= 1'b1;
        end
      end
      dsct_pkg::OP_RS_CALC: begin
        soon_q <= sat_add(now_q, TB'(minl_q));
        far_q  <= sat_add(now_q, TB'(maxl_q));
      end
      default: ;
    endcase
  end

  // Control state: configuration, timebase, compare, queue length, pending, walk, fire count, output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q     <= dsct_pkg::TICKS_PER_US_RST;
      minl_q    <= dsct_pkg::MIN_LEAD_RST;
      maxl_q    <= dsct_pkg::MAX_LEAD_RST;
      now_q     <= '0;
      sub_q     <= '0;
      cmp_q     <= '1;
      qlen_q    <= '0;
      walk_q    <= '0;
      n_q       <= '0;
      pend_q    <= '0;
      ov_q      <= 1'b0;
      okind_q   <= 1'b0;
      olast_q   <= 1'b0;
      ocalled_q <= 1'b0;
      oent_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          dsct_pkg::CFG_TICKS_PER_US: tpu_q  <= cfg_wdata_i[7:0];
          dsct_pkg::CFG_MIN_LEAD:     minl_q <= cfg_wdata_i[15:0];
          dsct_pkg::CFG_MAX_LEAD:     maxl_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      // Drop a taken result unless a new one loads this cycle
      if (ov_q && out_ready_i && !out_load) ov_q <= 1'b0;
      case (ctl_i.op)
        dsct_pkg::OP_TICK: begin
          n_q <= '0;
          if (sub_inc >= {1'b0, tpu_q}) begin
            sub_q <= '0;
            now_q <= now_q + TB'(1);
          end else begin
            sub_q <= sub_inc[7:0];
          end
        end
        dsct_pkg::OP_WALK_CLR: walk_q <= '0;
        dsct_pkg::OP_WALK_INC: walk_q <= walk_q + WW'(1);
        dsct_pkg::OP_RM_SHIFT: qlen_q <= qlen_q - WW'(1);
        dsct_pkg::OP_CANCEL:   pend_q[ent_q] <= 1'b0;
        dsct_pkg::OP_SCHED: begin
          pend_q[ent_q] <= 1'b1;
          walk_q        <= '0;
        end
        dsct_pkg::OP_EN_INSERT: qlen_q <= qlen_q + WW'(1);
        dsct_pkg::OP_FIRE_HEAD: begin
          qlen_q            <= qlen_q - WW'(1);
          pend_q[qent_q[0]] <= 1'b0;
        end
        dsct_pkg::OP_FIRE_PER: begin
          if (per_rd_q != '0) begin
            pend_q[ent_q] <= 1'b1;
            walk_q        <= '0;
          end
        end
        dsct_pkg::OP_ACK: begin
          ov_q      <= 1'b1;
          okind_q   <= 1'b0;
          oent_q    <= e_q;
          ocalled_q <= called_q;
          olast_q   <= 1'b1;
        end
        dsct_pkg::OP_FIRE_OUT: begin
          ov_q      <= 1'b1;
          okind_q   <= 1'b1;
          oent_q    <= 4'(ent_q);
          ocalled_q <= called_q;
          olast_q   <= !fire_more;
          n_q       <= n_q + NW'(1);
        end
        dsct_pkg::OP_RS_PICK: begin
          if (qlen_q == '0) cmp_q <= far_q;
          else if (qdl_q[0] <= soon_q) cmp_q <= soon_q;
          else if (qdl_q[0] < far_q) cmp_q <= qdl_q[0];
          else cmp_q <= far_q;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = {3'b000, ocalled_q, oent_q};
  assign out_kind_o  = okind_q;
  assign out_last_o  = olast_q;

endmodule

// File: design/deadline_sorted_callout_timer_core.sv
// Deadline sorted callout timer: one request at a time. A query or an invalid
// entry is answered without a queue walk; a schedule or cancel walks the queue
// slots, one per cycle. A tick fires the due entries and re-inserts each
// periodic one in sorted order.
// Reset is asynchronous, active low: queue empty, time zero, compare all ones.
`timescale 1ns / 1ps

module deadline_sorted_callout_timer_core #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned MAX_FIRE  = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [dsct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // entry[3:0], time_value[51:4],
                                                           // interval[99:52], zero fill
  input  logic [2:0]                       s_axis_tuser,   // cmd[2:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [dsct_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // entry[3:0], called[4]
  output logic [0:0]                       m_axis_tuser,   // kind[0]
  output logic                             m_axis_tlast,
  input  logic                             cfg_we_i,
  input  logic [dsct_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [dsct_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  dsct_pkg::ctl_t ctl;
  dsct_pkg::st_t  st;

  dsct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .ctl_o      (ctl)
  );

  dsct_dpath #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS),
    .MAX_FIRE  (MAX_FIRE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_cmd_i    (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser[0]),
    .out_last_o  (m_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctl_i       (ctl),
    .st_o        (st)
  );

  // A new result is loaded only when the output register is free
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.op == dsct_pkg::OP_ACK || ctl.op == dsct_pkg::OP_FIRE_OUT) |-> st.out_free)
    else $error("result loaded over a waiting result");

  // The queue never holds more slots than entries
  a_qlen: assert property (@(posedge clk_i) disable iff (!rst_ni) !st.qlen_over)
    else $error("queue length beyond table size");

  // A taken request blocks the next one until its work is done
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in work");

  // A firing result, once loaded, is valid and marked with the firing kind
  a_fire_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.op == dsct_pkg::OP_FIRE_OUT) |=> (m_axis_tvalid && m_axis_tuser[0]))
    else $error("firing result lost its kind");

endmodule
